// ----- rtl/srsg_pkg.sv -----
`default_nettype none

package srsg_pkg;

  // Default table depth
  localparam int unsigned SEGMENTS_DEF = 16;

  // Field widths
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned LENGTH_W   = 16;
  localparam int unsigned STEP_W     = 32;
  localparam int unsigned INTERVAL_W = 16;

  // Serial divider dividend width (step count, or ramp product)
  localparam int unsigned DIVIDEND_W = 32;

  localparam logic [INTERVAL_W-1:0] INTERVAL_RST = INTERVAL_W'(1);

  // One table entry
  typedef struct packed {
    logic                is_ramp;
    logic [LENGTH_W-1:0] length;
    logic [LEVEL_W-1:0]  start_level;
    logic [LEVEL_W-1:0]  end_level;
  } seg_t;

endpackage

`default_nettype wire

// ----- rtl/srsg_div.sv -----
`default_nettype none

// Bit-serial restoring divider: one quotient bit per cycle.
module srsg_div #(
  parameter int unsigned DIVISOR_W = 20
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              start_i,
  input  wire logic [srsg_pkg::DIVIDEND_W-1:0]   dividend_i,
  input  wire logic [DIVISOR_W-1:0]              divisor_i,
  output logic                                   done_o,
  output logic [srsg_pkg::DIVIDEND_W-1:0]        quotient_o,
  output logic [DIVISOR_W-1:0]                   remainder_o
);
  import srsg_pkg::*;

  localparam int unsigned CNT_W = $clog2(DIVIDEND_W);

  logic                  run_q;
  logic                  done_q;
  logic [CNT_W-1:0]      cnt_q;
  logic [DIVIDEND_W-1:0] dvd_q;
  logic [DIVISOR_W-1:0]  rem_q;
  logic [DIVISOR_W-1:0]  dsr_q;

  logic [DIVISOR_W:0]    trial;
  logic [DIVISOR_W:0]    trial_sub;
  logic                  fits;

  // Bring down the next dividend bit and try the subtraction
  assign trial     = {rem_q, dvd_q[DIVIDEND_W-1]};
  assign trial_sub = trial - {1'b0, dsr_q};
  assign fits      = (trial >= {1'b0, dsr_q});

  // Sequence control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + CNT_W'(1);
        if (cnt_q == CNT_W'(DIVIDEND_W - 1)) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Shift dividend out and quotient in through one register
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (run_q) begin
      dvd_q <= {dvd_q[DIVIDEND_W-2:0], fits};
      rem_q <= fits ? trial_sub[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
    end
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

endmodule

`default_nettype wire

// ----- rtl/segment_ramp_schedule_generator.sv -----
`default_nettype none

// Channel      Direction  Handshake                 Fields
// request      in         start_i & !busy_o         operation, step_count, seg_index,
//                                                   seg_is_ramp, seg_length,
//                                                   seg_start_level, seg_end_level
// result       out        done_o, one cycle         level, report, matched
// interval     in         cfg_we_i                  cfg_wdata_i (report interval)
//
// A write request passes through ST_WRITE before done_o; a query with zero period
// answers the next cycle. A query runs a bit-serial modulo by the period, then walks
// the entries, each a table read (ST_WALK_RD) and a compare (ST_WALK_CMP); a ramp adds
// a shift-add multiply and two more passes of the serial divider.
// Reset clears the table valid bits, the period and the report history at once.
// busy_o holds off new requests; the result strobe cannot be stalled.
module segment_ramp_schedule_generator #(
  parameter int unsigned SEGMENTS = srsg_pkg::SEGMENTS_DEF
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                start_i,
  output logic                                     busy_o,
  input  wire logic                                operation_i,
  input  wire logic [srsg_pkg::STEP_W-1:0]         step_count_i,
  input  wire logic [3:0]                          seg_index_i,
  input  wire logic                                seg_is_ramp_i,
  input  wire logic [srsg_pkg::LENGTH_W-1:0]       seg_length_i,
  input  wire logic [srsg_pkg::LEVEL_W-1:0]        seg_start_level_i,
  input  wire logic [srsg_pkg::LEVEL_W-1:0]        seg_end_level_i,
  input  wire logic                                cfg_we_i,
  input  wire logic [srsg_pkg::INTERVAL_W-1:0]     cfg_wdata_i,
  output logic                                     done_o,
  output logic [srsg_pkg::LEVEL_W-1:0]             level_o,
  output logic                                     report_o,
  output logic                                     matched_o
);
  import srsg_pkg::*;

  localparam int unsigned IW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int unsigned LW = IW + 1;
  localparam int unsigned PW = LENGTH_W + $clog2(SEGMENTS);
  localparam int unsigned MCNT_W = $clog2(LEVEL_W);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_WRITE    = 3'd1;
  localparam logic [2:0] ST_MOD      = 3'd2;
  localparam logic [2:0] ST_WALK_RD  = 3'd3;
  localparam logic [2:0] ST_WALK_CMP = 3'd4;
  localparam logic [2:0] ST_MUL      = 3'd5;
  localparam logic [2:0] ST_DIV      = 3'd6;
  localparam logic [2:0] ST_IVM      = 3'd7;

  localparam logic [LW-1:0] LAST_NONE = '1;

  // Control and history
  logic [2:0]               state_q;
  logic [PW-1:0]            period_q;
  logic [INTERVAL_W-1:0]    iv_q;
  logic [LW-1:0]            last_seg_q;
  logic signed [LEVEL_W:0]  lrl_q;
  logic [SEGMENTS-1:0]      seg_vld_q;
  logic                     div_go_q;

  // Table storage and read port
  seg_t                     seg_mem [SEGMENTS];
  seg_t                     rd_q;
  logic                     rd_vld_q;
  logic [IW-1:0]            rd_addr;

  // Request payload and walk state
  logic [IW-1:0]            wr_addr_q;
  logic                     wr_ok_q;
  seg_t                     wr_ent_q;
  logic [IW-1:0]            k_q;
  logic [PW-1:0]            pos_q;
  seg_t                     cur_q;

  // Serial multiplier
  logic [LEVEL_W-1:0]       mcand_q;
  logic [LEVEL_W-1:0]       mhi_q;
  logic [LEVEL_W-1:0]       mlo_q;
  logic [MCNT_W-1:0]        mcnt_q;
  logic [LEVEL_W:0]         msum;

  logic [LEVEL_W-1:0]       quo_q;

  // Result registers
  logic                     done_q;
  logic [LEVEL_W-1:0]       level_q;
  logic                     report_q;
  logic                     matched_q;

  // Divider hookup
  logic                     div_start;
  logic [DIVIDEND_W-1:0]    div_dividend;
  logic [PW-1:0]            div_divisor;
  logic                     div_done;
  logic [DIVIDEND_W-1:0]    div_quo;
  logic [PW-1:0]            div_rem;

  logic                     accept;
  logic                     idx_ok;
  logic [LENGTH_W-1:0]      cur_len;
  logic                     pos_hit;
  logic                     changed;
  logic [LEVEL_W-1:0]       iv_eff;
  logic                     rising;
  logic                     falling;
  logic [LEVEL_W-1:0]       ramp_v;
  logic signed [LEVEL_W:0]  ramp_vs;
  logic                     ramp_rep;

  assign accept  = start_i && (state_q == ST_IDLE);
  assign busy_o  = (state_q != ST_IDLE);
  assign idx_ok  = ({28'd0, seg_index_i} < 32'(SEGMENTS));
  assign rd_addr = (state_q == ST_IDLE) ? IW'(seg_index_i) : k_q;

  assign cur_len = rd_vld_q ? rd_q.length : '0;
  assign pos_hit = (pos_q < PW'(cur_len));
  assign changed = ({1'b0, k_q} != last_seg_q);
  assign iv_eff  = (iv_q == '0) ? INTERVAL_RST : iv_q;

  // Ramp value from the finished quotient
  assign rising   = (cur_q.end_level > cur_q.start_level);
  assign falling  = (cur_q.end_level < cur_q.start_level);
  assign ramp_v   = rising ? (cur_q.start_level + quo_q) : (cur_q.start_level - quo_q);
  assign ramp_vs  = signed'({1'b0, ramp_v});
  assign ramp_rep = changed ||
                    ((div_rem == '0) &&
                     ((falling && (ramp_vs < lrl_q)) || (rising && (ramp_vs > lrl_q))));

  // One multiply step: add multiplicand on the low bit, shift right
  assign msum = {1'b0, mhi_q} + (mlo_q[0] ? {1'b0, mcand_q} : '0);

  // Share the divider: modulo by period, ramp quotient, interval check
  assign div_start = (accept && !operation_i && (period_q != '0)) || div_go_q;

  always_comb begin
    div_dividend = {16'd0, pos_q[LENGTH_W-1:0]};
    div_divisor  = PW'(iv_eff);
    unique case (state_q)
      ST_IDLE: begin
        div_dividend = step_count_i;
        div_divisor  = period_q;
      end
      ST_DIV: begin
        div_dividend = {mhi_q, mlo_q};
        div_divisor  = PW'(cur_q.length);
      end
      default: begin
        div_dividend = {16'd0, pos_q[LENGTH_W-1:0]};
        div_divisor  = PW'(iv_eff);
      end
    endcase
  end

  srsg_div #(
    .DIVISOR_W (PW)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (div_dividend),
    .divisor_i   (div_divisor),
    .done_o      (div_done),
    .quotient_o  (div_quo),
    .remainder_o (div_rem)
  );

  // Table memory: registered read, write on update
  always_ff @(posedge clk_i) begin
    rd_q     <= seg_mem[rd_addr];
    rd_vld_q <= seg_vld_q[rd_addr];
    if ((state_q == ST_WRITE) && wr_ok_q) begin
      seg_mem[wr_addr_q] <= wr_ent_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      wr_addr_q <= IW'(seg_index_i);
      wr_ok_q   <= idx_ok;
      wr_ent_q  <= '{is_ramp: seg_is_ramp_i, length: seg_length_i,
                     start_level: seg_start_level_i, end_level: seg_end_level_i};
    end
    if (state_q == ST_MOD && div_done) begin
      pos_q <= div_rem;
      k_q   <= '0;
    end
    if (state_q == ST_WALK_CMP) begin
      if (pos_hit) begin
        cur_q   <= rd_q;
        mcand_q <= (rd_q.end_level < rd_q.start_level) ?
                   (rd_q.start_level - rd_q.end_level) :
                   (rd_q.end_level - rd_q.start_level);
        mhi_q   <= '0;
        mlo_q   <= pos_q[LEVEL_W-1:0];
        mcnt_q  <= '0;
      end else begin
        pos_q <= pos_q - PW'(cur_len);
        k_q   <= k_q + IW'(1);
      end
    end
    if (state_q == ST_MUL) begin
      mhi_q  <= msum[LEVEL_W:1];
      mlo_q  <= {msum[0], mlo_q[LEVEL_W-1:1]};
      mcnt_q <= mcnt_q + MCNT_W'(1);
    end
    if (state_q == ST_DIV && div_done) begin
      quo_q <= div_quo[LEVEL_W-1:0];
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (accept && (operation_i || (period_q == '0))) begin
      level_q   <= operation_i ? '0 : LEVEL_W'(1);
      report_q  <= 1'b0;
      matched_q <= 1'b0;
    end
    if (state_q == ST_WRITE) begin
      level_q   <= '0;
      report_q  <= 1'b0;
      matched_q <= 1'b0;
    end
    if (state_q == ST_WALK_CMP) begin
      if (pos_hit && !rd_q.is_ramp) begin
        level_q   <= rd_q.start_level;
        report_q  <= changed;
        matched_q <= 1'b1;
      end else if (!pos_hit) begin
        level_q   <= LEVEL_W'(1);
        report_q  <= 1'b0;
        matched_q <= 1'b0;
      end
    end
    if (state_q == ST_IVM && div_done) begin
      level_q   <= ramp_v;
      report_q  <= ramp_rep;
      matched_q <= 1'b1;
    end
  end

  // Sequencer, period, history and valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      period_q   <= '0;
      iv_q       <= INTERVAL_RST;
      last_seg_q <= LAST_NONE;
      lrl_q      <= '1;
      seg_vld_q  <= '0;
      div_go_q   <= 1'b0;
      done_q     <= 1'b0;
    end else begin
      done_q   <= 1'b0;
      div_go_q <= 1'b0;
      if (cfg_we_i) begin
        iv_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (operation_i) begin
              state_q <= ST_WRITE;
            end else if (period_q == '0) begin
              done_q <= 1'b1;
            end else begin
              state_q <= ST_MOD;
            end
          end
        end
        ST_WRITE: begin
          // Swap old length for new in the running period
          if (wr_ok_q) begin
            period_q             <= period_q - (rd_vld_q ? PW'(rd_q.length) : '0)
                                    + PW'(wr_ent_q.length);
            seg_vld_q[wr_addr_q] <= 1'b1;
          end
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
        end
        ST_MOD: begin
          if (div_done) begin
            state_q <= ST_WALK_RD;
          end
        end
        ST_WALK_RD: begin
          state_q <= ST_WALK_CMP;
        end
        ST_WALK_CMP: begin
          if (pos_hit) begin
            if (rd_q.is_ramp) begin
              state_q <= ST_MUL;
            end else begin
              if (changed) begin
                last_seg_q <= {1'b0, k_q};
              end
              done_q  <= 1'b1;
              state_q <= ST_IDLE;
            end
          end else if (k_q == IW'(SEGMENTS - 1)) begin
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end else begin
            state_q <= ST_WALK_RD;
          end
        end
        ST_MUL: begin
          if (mcnt_q == MCNT_W'(LEVEL_W - 1)) begin
            div_go_q <= 1'b1;
            state_q  <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            div_go_q <= 1'b1;
            state_q  <= ST_IVM;
          end
        end
        ST_IVM: begin
          if (div_done) begin
            if (ramp_rep) begin
              last_seg_q <= {1'b0, k_q};
              lrl_q      <= ramp_vs;
            end
            done_q  <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign done_o    = done_q;
  assign level_o   = level_q;
  assign report_o  = report_q;
  assign matched_o = matched_q;

endmodule

`default_nettype wire
